[design/pcx_rle_line_decoder_macros.svh]
// ----------------------------------------------------------------------------
// PCX RLE line decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_LINE_DECODER_MACROS_SVH
`define PCX_RLE_LINE_DECODER_MACROS_SVH

// Same-cycle implication
`define PCXRLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PCXRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pcxrle_pkg.sv]
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Types and constants shared by the PCX RLE line decoder modules.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  // Run marker: a byte at or above this value starts a run
  localparam logic [7:0] RUN_MARK = 8'd192;
  // Run count bits of a marker byte
  localparam logic [5:0] RUN_MASK = 6'h3F;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_LINE      = 2'd1,
    KIND_TRUNC     = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LINE_LENGTH = 2'd0,
    CFG_PAD_COUNT   = 2'd1,
    CFG_BYTE_STRIDE = 2'd2
  } cfg_index_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // input transaction accepted, plan the byte
    logic emit_pixel;  // load one pixel result
    logic emit_term;   // load the closing result (line, truncated, malformed)
    logic last;        // mark loaded result as final one of the byte
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_zero;    // no pixels left to emit for this byte
    logic cnt_one;     // exactly one pixel left
    logic has_term;    // a closing result is pending
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

[design/pcxrle_dp.sv]
// ----------------------------------------------------------------------------
// pcxrle_dp
// Datapath: configuration registers, line counters, run state, per-byte
// plan and the output register.
// ----------------------------------------------------------------------------
`include "pcx_rle_line_decoder_macros.svh"

module pcxrle_dp (
  input  logic                 clk,
  input  logic                 rst,
  // config port
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  // input payload
  input  logic [7:0]           data_byte,
  input  logic                 is_last,
  // output channel
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [1:0]           kind,
  output logic [7:0]           pixel_value,
  output logic [17:0]          write_offset,
  output logic                 last,
  // controller link
  input  pcxrle_pkg::cmd_t     cmd,
  output pcxrle_pkg::status_t  status
);

  // Configuration
  logic [15:0] line_length;
  logic [15:0] pad_count;
  logic [2:0]  byte_stride;

  // Line and run state
  logic [15:0] pixels_left;
  logic [15:0] pad_left;
  logic        run_pending;
  logic [5:0]  run_length;
  logic        halted;

  // Work on the current byte
  logic [7:0]  value;
  logic [5:0]  cnt;
  logic        has_term;
  logic [1:0]  term_kind;

  // Plan of the incoming byte
  logic [15:0] pad_left_next;
  logic        run_pending_next;
  logic [5:0]  run_length_next;
  logic [5:0]  n_emit;
  logic [5:0]  pad_take;
  logic        run_err;
  logic [15:0] pixels_after;
  logic        term_next;
  logic [1:0]  term_kind_next;
  logic        halted_next;

  logic [15:0] eff_line;
  logic [15:0] pix_index;
  logic [18:0] offset_full;
  logic        out_load;

  // Restart values after a config write
  logic [15:0] cfg_line;
  logic [15:0] cfg_pad;
  logic        cfg_known;

  assign eff_line = (line_length == 16'd0) ? 16'd1 : line_length;

  // Per-byte plan: pixels to emit, padding consumed, run state, closing result
  always_comb begin
    pad_left_next    = pad_left;
    run_pending_next = run_pending;
    run_length_next  = run_length;
    n_emit           = 6'd0;
    pad_take         = 6'd0;
    run_err          = 1'b0;
    if (run_pending) begin
      run_pending_next = 1'b0;
      run_length_next  = 6'd0;
      if (pixels_left != 16'd0) begin
        if ({10'd0, run_length} < pixels_left) begin
          n_emit = run_length;
        end else begin
          n_emit = pixels_left[5:0];
        end
        pad_take = run_length - n_emit;
      end else begin
        pad_take = run_length;
      end
      if ({10'd0, pad_take} > pad_left) begin
        run_err       = 1'b1;
        pad_left_next = 16'd0;
      end else begin
        pad_left_next = pad_left - {10'd0, pad_take};
      end
    end else if (data_byte >= pcxrle_pkg::RUN_MARK) begin
      run_pending_next = 1'b1;
      run_length_next  = data_byte[5:0] & pcxrle_pkg::RUN_MASK;
    end else if (pixels_left != 16'd0) begin
      n_emit = 6'd1;
    end else if (pad_left != 16'd0) begin
      pad_left_next = pad_left - 16'd1;
    end
  end

  // Closing result of the byte
  assign pixels_after = pixels_left - {10'd0, n_emit};

  always_comb begin
    term_next      = 1'b0;
    term_kind_next = pcxrle_pkg::KIND_PIXEL;
    if (run_err) begin
      term_next      = 1'b1;
      term_kind_next = pcxrle_pkg::KIND_MALFORMED;
    end else if (!run_pending_next && pixels_after == 16'd0 && pad_left_next == 16'd0) begin
      term_next      = 1'b1;
      term_kind_next = pcxrle_pkg::KIND_LINE;
    end else if (is_last) begin
      term_next      = 1'b1;
      term_kind_next = pcxrle_pkg::KIND_TRUNC;
    end
  end

  assign halted_next = run_err ||
                       (term_next && term_kind_next == pcxrle_pkg::KIND_TRUNC);

  // Register values seen by a line restart after a config write
  always_comb begin
    cfg_line = line_length;
    cfg_pad  = pad_count;
    if (cfg_index == pcxrle_pkg::CFG_LINE_LENGTH) begin
      cfg_line = cfg_data;
    end
    if (cfg_index == pcxrle_pkg::CFG_PAD_COUNT) begin
      cfg_pad = cfg_data;
    end
  end

  // Only a write to an existing register restarts the line
  assign cfg_known = (cfg_index == pcxrle_pkg::CFG_LINE_LENGTH) ||
                     (cfg_index == pcxrle_pkg::CFG_PAD_COUNT) ||
                     (cfg_index == pcxrle_pkg::CFG_BYTE_STRIDE);

  // Write offset of the next pixel
  assign pix_index   = eff_line - pixels_left;
  assign offset_full = {3'd0, pix_index} * {16'd0, byte_stride};

  assign out_load = cmd.emit_pixel || cmd.emit_term;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= 16'd1;
      pad_count   <= 16'd0;
      byte_stride <= 3'd1;
      pixels_left <= 16'd1;
      pad_left    <= 16'd0;
      run_pending <= 1'b0;
      run_length  <= 6'd0;
      halted      <= 1'b0;
      cnt         <= 6'd0;
      has_term    <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_known) begin
        pixels_left <= (cfg_line == 16'd0) ? 16'd1 : cfg_line;
        pad_left    <= cfg_pad;
        run_pending <= 1'b0;
        run_length  <= 6'd0;
      end
      unique case (cfg_index)
        pcxrle_pkg::CFG_LINE_LENGTH: line_length <= cfg_data;
        pcxrle_pkg::CFG_PAD_COUNT:   pad_count   <= cfg_data;
        pcxrle_pkg::CFG_BYTE_STRIDE: byte_stride <= cfg_data[2:0];
        default: ;
      endcase
    end else if (cmd.load) begin
      if (halted) begin
        cnt      <= 6'd0;
        has_term <= 1'b0;
      end else begin
        pad_left    <= pad_left_next;
        run_pending <= run_pending_next;
        run_length  <= run_length_next;
        cnt         <= n_emit;
        has_term    <= term_next;
        halted      <= halted_next;
      end
    end else if (cmd.emit_pixel) begin
      pixels_left <= pixels_left - 16'd1;
      cnt         <= cnt - 6'd1;
    end else if (cmd.emit_term) begin
      has_term <= 1'b0;
      if (term_kind == pcxrle_pkg::KIND_LINE) begin
        pixels_left <= eff_line;
        pad_left    <= pad_count;
        run_pending <= 1'b0;
        run_length  <= 6'd0;
      end
    end
  end

  // Byte payload captured with the plan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value     <= data_byte;
      term_kind <= term_kind_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pixel) begin
      kind         <= pcxrle_pkg::KIND_PIXEL;
      pixel_value  <= value;
      write_offset <= offset_full[17:0];
      last         <= cmd.last;
    end else if (cmd.emit_term) begin
      kind         <= term_kind;
      pixel_value  <= 8'd0;
      write_offset <= 18'd0;
      last         <= cmd.last;
    end
  end

  assign status.cnt_zero = (cnt == 6'd0);
  assign status.cnt_one  = (cnt == 6'd1);
  assign status.has_term = has_term;
  assign status.out_free = !out_valid || !out_stall;

  // Checks
  `PCXRLE_ASSERT_NOW(a_pixel_has_count, cmd.emit_pixel, cnt != 6'd0 && pixels_left != 16'd0, "pixel emitted with no count left")
  `PCXRLE_ASSERT_NOW(a_load_when_free, out_load, status.out_free, "output register overwritten")
  `PCXRLE_ASSERT_NEXT(a_line_restart, cmd.emit_term && term_kind == pcxrle_pkg::KIND_LINE, pixels_left == $past(eff_line) && !run_pending, "line not restarted")
  `PCXRLE_ASSERT_NEXT(a_halt_sticks, halted, halted, "halt released without reset")

endmodule

[design/pcxrle_ctrl.sv]
// ----------------------------------------------------------------------------
// pcxrle_ctrl
// Controller: accepts one byte, then steps the datapath through its pixel
// results and the closing result, one per free output slot.
// ----------------------------------------------------------------------------
module pcxrle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pcxrle_pkg::status_t  status,
  output pcxrle_pkg::cmd_t     cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  // Command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.out_free) begin
          if (!status.cnt_zero) begin
            cmd.emit_pixel = 1'b1;
            cmd.last       = status.cnt_one && !status.has_term;
            if (cmd.last) begin
              state_next = ST_IDLE;
            end
          end else if (status.has_term) begin
            cmd.emit_term = 1'b1;
            cmd.last      = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/pcx_rle_line_decoder.sv]
// The plan of a byte is registered when it is accepted; its results are then
// loaded into the single output register, one result per cycle while the
// output does not stall. The next byte is not accepted until all results of
// the current byte (pixels and closing result, if any) have been loaded.
// The next byte is accepted while the final result still waits downstream.
// Reset (rst, synchronous): registers to defaults, counters reloaded, no sweep.
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder
// PCX run-length line decoder: bytes in, pixels with write offsets and
// line/error markers out.
// ----------------------------------------------------------------------------
module pcx_rle_line_decoder (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  pixel_value,
  output logic [17:0] write_offset,
  output logic        last
);

  pcxrle_pkg::cmd_t    cmd;
  pcxrle_pkg::status_t status;

  pcxrle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pcxrle_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .is_last      (is_last),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .kind         (kind),
    .pixel_value  (pixel_value),
    .write_offset (write_offset),
    .last         (last),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
